/* src/qspi_sh_pkg.sv */
// Shared types and constants of the quad/single SPI flash master shifter.
`default_nettype none
package qspi_sh_pkg;

  localparam int unsigned DummyMax = 63;
  localparam int unsigned CntW     = 6;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  // Item kinds carried on the slave tuser; the fourth code is unused.
  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_DUMMY = 2'd1,
    KIND_RECV  = 2'd2
  } kind_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;   // latch the incoming word and open the frame if needed
    logic pulse;    // emit one clock pulse result
    logic release_cs; // emit the chip-select release result
    logic fin;      // this pulse is the final pulse of the item
    logic last;     // this result is the final one of the item
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [CntW-1:0] pulses;  // pulse count of the word on the slave side
  } stat_t;

endpackage
`default_nettype wire

/* src/spi_quad_flash_master_shifter.sv */
// Top level of the SPI flash master shifter: controller and datapath.
// Once accepted, a word gives one result per cycle while the
// master side takes them: 8 pulses for a single-line byte, 2 for a quad byte, the dummy count
// for a dummy run, plus one release result when the word ends the frame.
// The first result is registered in the state that follows acceptance.
// Reset (rst_ni low, asynchronous) closes the frame, lines outputs at one; cs_n is not reset.
`default_nettype none
module spi_quad_flash_master_shifter (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid,
  output logic        s_tready,
  // tx_byte[7:0], quad_mode[8], dummy_count[14:9], line_samples[22:15], zero[23]
  input  wire  [23:0] s_tdata,
  // kind[1:0]
  input  wire  [1:0]  s_tuser,
  // frame_end
  input  wire         s_tlast,
  output logic        m_tvalid,
  input  wire         m_tready,
  // cs_n[0], data_out[4:1], drive_mask[8:5], read_byte[16:9], zero[23:17]
  output logic [23:0] m_tdata,
  // clock_pulse[0], byte_valid[1]
  output logic [1:0]  m_tuser,
  // last
  output logic        m_tlast
);

  qspi_sh_pkg::cmd_t  cmd;
  qspi_sh_pkg::stat_t stat;

  qspi_sh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tlast_i  (s_tlast),
    .s_tready_o (s_tready),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  qspi_sh_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_tdata),
    .s_tuser_i (s_tuser),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .m_tdata_o (m_tdata),
    .m_tuser_o (m_tuser),
    .m_tlast_o (m_tlast)
  );

endmodule
`default_nettype wire

/* src/qspi_sh_ctrl.sv */
// Controller state machine of the SPI flash master shifter.
`default_nettype none
module qspi_sh_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       s_tvalid_i,
  input  wire                       s_tlast_i,
  output logic                      s_tready_o,
  output logic                      m_tvalid_o,
  input  wire                       m_tready_i,
  input  wire qspi_sh_pkg::stat_t   stat_i,
  output qspi_sh_pkg::cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PULSE,
    ST_RELEASE
  } state_e;

  state_e                         state_q, state_d;
  logic [qspi_sh_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                           fe_q, fe_d;
  logic                           m_tvalid_q, m_tvalid_d;
  logic                           out_free;
  logic                           emit;
  logic                           accept;
  logic                           fin;

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_tvalid_q;
  assign accept     = s_tvalid_i && s_tready_o;
  assign out_free   = !m_tvalid_q || m_tready_i;
  assign emit       = (state_q != ST_IDLE) && out_free;
  assign fin        = (cnt_q == qspi_sh_pkg::CntW'(1));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    fe_d       = fe_q;
    m_tvalid_d = m_tvalid_q && !m_tready_i;
    cmd_o      = '0;
    cmd_o.accept = accept;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = stat_i.pulses;
          fe_d  = s_tlast_i;
          if (stat_i.pulses != '0) begin
            state_d = ST_PULSE;
          end else if (s_tlast_i) begin
            state_d = ST_RELEASE;
          end
        end
      end
      ST_PULSE: begin
        if (emit) begin
          cmd_o.pulse = 1'b1;
          cmd_o.fin   = fin;
          cmd_o.last  = fin && !fe_q;
          m_tvalid_d  = 1'b1;
          cnt_d       = cnt_q - qspi_sh_pkg::CntW'(1);
          if (fin) begin
            state_d = fe_q ? ST_RELEASE : ST_IDLE;
          end
        end
      end
      ST_RELEASE: begin
        if (emit) begin
          cmd_o.release_cs = 1'b1;
          cmd_o.last       = 1'b1;
          m_tvalid_d       = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      fe_q       <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      fe_q       <= fe_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  // A pulse run always has pulses left to give.
  a_pulse_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PULSE) |-> (cnt_q != '0))
    else $error("pulse state with empty counter");

  // A word that ends the frame always leads to a release, so no word follows at once.
  a_fe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_tlast_i) |=> !s_tready_o)
    else $error("frame end word did not keep the shifter busy");

  // The final pulse of a word without frame end returns to idle.
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PULSE && emit && fin && !fe_q) |=> (state_q == ST_IDLE))
    else $error("final pulse did not end the word");

endmodule
`default_nettype wire

/* src/qspi_sh_dp.sv */
// Datapath of the SPI flash master shifter: line state, shift register, result register.
`default_nettype none
module qspi_sh_dp (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire  [qspi_sh_pkg::InDataW-1:0]       s_tdata_i,
  input  wire  [1:0]                            s_tuser_i,
  input  wire qspi_sh_pkg::cmd_t                cmd_i,
  output qspi_sh_pkg::stat_t                    stat_o,
  output logic [qspi_sh_pkg::OutDataW-1:0]      m_tdata_o,
  output logic [1:0]                            m_tuser_o,
  output logic                                  m_tlast_o
);

  // Fields of the incoming word.
  logic [7:0] in_tx;
  logic       in_quad;
  logic [5:0] in_dummy;
  logic [7:0] in_samples;
  logic [1:0] in_kind;

  assign in_tx      = s_tdata_i[7:0];
  assign in_quad    = s_tdata_i[8];
  assign in_dummy   = s_tdata_i[14:9];
  assign in_samples = s_tdata_i[22:15];
  assign in_kind    = s_tuser_i;

  // Line state.
  logic       open_q, open_d;
  logic [3:0] lvl_q, lvl_d;
  logic       inp_q, inp_d;
  logic       quad_q, quad_d;

  // Item held while its pulses run.
  logic [1:0] kind_q;
  logic [7:0] sh_q, sh_d;
  logic [7:0] smp_q;

  // Result register.
  logic       cs_q, clk_q, bv_q, last_q;
  logic [3:0] dout_q, mask_q;
  logic [7:0] rb_q;

  logic       quad_eff;
  logic [3:0] mask;
  logic [3:0] lvl_pulse;
  logic       is_send, is_recv;

  assign quad_eff = open_q ? quad_q : in_quad;
  assign mask     = !inp_q ? 4'hF : (quad_q ? 4'h0 : 4'hD);
  assign is_send  = (kind_q == qspi_sh_pkg::KIND_SEND);
  assign is_recv  = (kind_q == qspi_sh_pkg::KIND_RECV);

  always_comb begin
    stat_o.pulses = '0;
    case (in_kind)
      qspi_sh_pkg::KIND_SEND,
      qspi_sh_pkg::KIND_RECV: begin
        stat_o.pulses = quad_eff ? qspi_sh_pkg::CntW'(2) : qspi_sh_pkg::CntW'(8);
      end
      qspi_sh_pkg::KIND_DUMMY: begin
        stat_o.pulses = (32'(in_dummy) > qspi_sh_pkg::DummyMax)
                      ? qspi_sh_pkg::CntW'(qspi_sh_pkg::DummyMax)
                      : in_dummy;
      end
      default: begin
        stat_o.pulses = '0;
      end
    endcase
  end

  // In single mode a send moves one bit onto line 0; in quad mode a whole nibble.
  always_comb begin
    lvl_pulse = lvl_q;
    sh_d      = sh_q;
    if (is_send) begin
      if (quad_q) begin
        lvl_pulse = sh_q[7:4];
        sh_d      = {sh_q[3:0], 4'h0};
      end else begin
        lvl_pulse = {lvl_q[3:1], sh_q[7]};
        sh_d      = {sh_q[6:0], 1'b0};
      end
    end
  end

  always_comb begin
    open_d = open_q;
    lvl_d  = lvl_q;
    inp_d  = inp_q;
    quad_d = quad_q;
    if (cmd_i.accept) begin
      open_d = 1'b1;
      if (!open_q) begin
        quad_d = in_quad;
        lvl_d  = in_quad ? 4'h0 : (lvl_q & 4'hE);
      end
      case (in_kind)
        qspi_sh_pkg::KIND_SEND:  inp_d = 1'b0;
        qspi_sh_pkg::KIND_RECV:  inp_d = 1'b1;
        default:                 inp_d = open_q ? inp_q : 1'b0;
      endcase
    end else if (cmd_i.pulse) begin
      lvl_d = lvl_pulse;
    end else if (cmd_i.release_cs) begin
      open_d = 1'b0;
      inp_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      lvl_q  <= 4'hF;
      inp_q  <= 1'b0;
      quad_q <= 1'b0;
    end else begin
      open_q <= open_d;
      lvl_q  <= lvl_d;
      inp_q  <= inp_d;
      quad_q <= quad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= in_kind;
      sh_q   <= in_tx;
      smp_q  <= in_samples;
    end else if (cmd_i.pulse) begin
      sh_q   <= sh_d;
    end
    if (cmd_i.pulse) begin
      cs_q   <= 1'b0;
      clk_q  <= 1'b1;
      dout_q <= lvl_pulse & mask;
      mask_q <= mask;
      rb_q   <= (cmd_i.fin && is_recv) ? smp_q : 8'h00;
      bv_q   <= cmd_i.fin && is_recv;
      last_q <= cmd_i.last;
    end else if (cmd_i.release_cs) begin
      cs_q   <= 1'b1;
      clk_q  <= 1'b0;
      dout_q <= lvl_q;
      mask_q <= 4'hF;
      rb_q   <= 8'h00;
      bv_q   <= 1'b0;
      last_q <= cmd_i.last;
    end
  end

  assign m_tdata_o = {7'h00, rb_q, mask_q, dout_q, cs_q};
  assign m_tuser_o = {bv_q, clk_q};
  assign m_tlast_o = last_q;

endmodule
`default_nettype wire
